// ----- hw/rtl/ifh_pkg.sv -----
package ifh_pkg;

    localparam int DEF_NUM_BINS   = 256;
    localparam int DEF_COUNT_BITS = 32;
    localparam int DEF_INDEX_BITS = 8;

    localparam int TIME_BITS      = 64;
    localparam int BIN_BITS       = 8;
    localparam int OP_BITS        = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [OP_BITS-1:0] OP_COUNT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERVAL_START = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERVAL_END   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGHEST_INDEX  = 2'd2;

    localparam logic [TIME_BITS-1:0] INTERVAL_START_RESET = '0;
    localparam logic [TIME_BITS-1:0] INTERVAL_END_RESET   = '1;
    localparam logic [BIN_BITS-1:0]  HIGHEST_INDEX_RESET  = 8'd255;

    typedef struct packed {
        logic [OP_BITS-1:0]   operation;
        logic [TIME_BITS-1:0] event_time;
        logic [BIN_BITS-1:0]  bin_index;
    } item_t;

    typedef struct packed {
        logic                counted;
        logic                out_of_range;
        logic                found;
        logic [BIN_BITS-1:0] best_index;
    } result_t;

    typedef enum logic [1:0] {
        CMD_COUNT,
        CMD_REPORT,
        CMD_CLEAR,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                out_of_range;
        logic [BIN_BITS-1:0] addr;
        logic [BIN_BITS-1:0] top;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_UPDATE,
        ST_CLEAR,
        ST_SCAN
    } back_state_t;

endpackage

// ----- hw/rtl/ifh_front.sv -----
module ifh_front #(
    parameter int NUM_BINS   = ifh_pkg::DEF_NUM_BINS,
    parameter int INDEX_BITS = ifh_pkg::DEF_INDEX_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  ifh_pkg::item_t                      item_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ifh_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ifh_pkg::TIME_BITS-1:0]       cfg_data,
    input  logic                                init_busy,
    input  logic                                q_full,
    output logic                                q_push,
    output ifh_pkg::cmd_t                       q_cmd
);

    localparam logic [ifh_pkg::BIN_BITS-1:0] IdxMask =
        (INDEX_BITS >= ifh_pkg::BIN_BITS) ? {ifh_pkg::BIN_BITS{1'b1}} :
        ifh_pkg::BIN_BITS'((1 << INDEX_BITS) - 1);
    localparam logic [ifh_pkg::BIN_BITS-1:0] LastBin = ifh_pkg::BIN_BITS'(NUM_BINS - 1);

    logic [ifh_pkg::TIME_BITS-1:0] interval_start_reg;
    logic [ifh_pkg::TIME_BITS-1:0] interval_end_reg;
    logic [ifh_pkg::BIN_BITS-1:0]  highest_index_reg;
    logic [ifh_pkg::BIN_BITS-1:0]  idx;
    logic                          idx_oor;
    logic                          in_interval;

    assign cfg_ready  = 1'b1;
    assign item_stall = init_busy || q_full;
    assign q_push     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_start_reg <= ifh_pkg::INTERVAL_START_RESET;
            interval_end_reg   <= ifh_pkg::INTERVAL_END_RESET;
            highest_index_reg  <= ifh_pkg::HIGHEST_INDEX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ifh_pkg::CFG_INTERVAL_START: interval_start_reg <= cfg_data;
                ifh_pkg::CFG_INTERVAL_END:   interval_end_reg   <= cfg_data;
                ifh_pkg::CFG_HIGHEST_INDEX:
                    highest_index_reg <= cfg_data[ifh_pkg::BIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        idx         = item_data.bin_index & IdxMask;
        idx_oor     = (int'(idx) > int'(highest_index_reg)) || (int'(idx) >= NUM_BINS);
        in_interval = (item_data.event_time >= interval_start_reg) &&
                      (item_data.event_time <= interval_end_reg);

        q_cmd.kind         = ifh_pkg::CMD_REPORT;
        q_cmd.out_of_range = 1'b0;
        q_cmd.addr         = idx;
        q_cmd.top          = (int'(highest_index_reg) < NUM_BINS - 1) ? highest_index_reg
                                                                        : LastBin;
        case (item_data.operation)
            ifh_pkg::OP_COUNT:
            begin
                if (idx_oor)
                begin
                    q_cmd.out_of_range = 1'b1;
                end
                else if (in_interval)
                begin
                    q_cmd.kind = ifh_pkg::CMD_COUNT;
                end
            end
            ifh_pkg::OP_CLEAR: q_cmd.kind = ifh_pkg::CMD_CLEAR;
            ifh_pkg::OP_QUERY: q_cmd.kind = ifh_pkg::CMD_QUERY;
            default: q_cmd.kind = ifh_pkg::CMD_REPORT;
        endcase
    end

endmodule

// ----- hw/rtl/ifh_queue.sv -----
module ifh_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ifh_pkg::cmd_t push_cmd,
    input  logic          pop,
    output ifh_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          empty
);

    localparam int PtrBits   = (ifh_pkg::QUEUE_DEPTH > 1) ? $clog2(ifh_pkg::QUEUE_DEPTH) : 1;
    localparam int CountBits = $clog2(ifh_pkg::QUEUE_DEPTH + 1);
    localparam logic [PtrBits-1:0]   LastPtr = PtrBits'(ifh_pkg::QUEUE_DEPTH - 1);
    localparam logic [CountBits-1:0] Depth   = CountBits'(ifh_pkg::QUEUE_DEPTH);

    ifh_pkg::cmd_t          slot_reg [ifh_pkg::QUEUE_DEPTH];
    logic [PtrBits-1:0]     wr_ptr_reg;
    logic [PtrBits-1:0]     wr_ptr_next;
    logic [PtrBits-1:0]     rd_ptr_reg;
    logic [PtrBits-1:0]     rd_ptr_next;
    logic [CountBits-1:0]   count_reg;
    logic [CountBits-1:0]   count_next;

    assign full     = (count_reg == Depth);
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/ifh_back.sv -----
module ifh_back #(
    parameter int NUM_BINS   = ifh_pkg::DEF_NUM_BINS,
    parameter int COUNT_BITS = ifh_pkg::DEF_COUNT_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  ifh_pkg::cmd_t    head_cmd,
    output logic             q_pop,
    output logic             init_busy,
    output logic             result_valid,
    input  logic             result_stall,
    output ifh_pkg::result_t result_data
);

    localparam int AddrBits = $clog2(NUM_BINS);
    localparam logic [AddrBits-1:0] LastAddr = AddrBits'(NUM_BINS - 1);

    logic [COUNT_BITS-1:0]  mem [NUM_BINS];
    logic [COUNT_BITS-1:0]  rd_data_reg;

    ifh_pkg::back_state_t   state_reg;
    ifh_pkg::back_state_t   state_next;
    logic [AddrBits-1:0]    addr_reg;
    logic [AddrBits-1:0]    addr_next;
    logic [AddrBits-1:0]    top_reg;
    logic [AddrBits-1:0]    top_next;
    logic [AddrBits-1:0]    best_reg;
    logic [AddrBits-1:0]    best_next;
    logic [COUNT_BITS-1:0]  max_reg;
    logic [COUNT_BITS-1:0]  max_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    ifh_pkg::result_t       result_reg;

    logic                   out_free;
    logic                   emit;
    ifh_pkg::result_t       emit_data;
    logic                   mem_we;
    logic [AddrBits-1:0]    mem_waddr;
    logic [COUNT_BITS-1:0]  mem_wdata;
    logic [AddrBits-1:0]    mem_raddr;

    assign out_free     = !result_valid_reg || !result_stall;
    assign init_busy    = (state_reg == ifh_pkg::ST_INIT);
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        top_next   = top_reg;
        best_next  = best_reg;
        max_next   = max_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        emit_data  = '0;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = '0;
        mem_raddr  = addr_reg;

        case (state_reg)
            ifh_pkg::ST_INIT,
            ifh_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (addr_reg == LastAddr)
                begin
                    addr_next  = '0;
                    state_next = ifh_pkg::ST_IDLE;
                    emit       = (state_reg == ifh_pkg::ST_CLEAR);
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ifh_pkg::ST_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    case (head_cmd.kind)
                        ifh_pkg::CMD_COUNT:
                        begin
                            mem_raddr  = AddrBits'(head_cmd.addr);
                            addr_next  = AddrBits'(head_cmd.addr);
                            state_next = ifh_pkg::ST_UPDATE;
                        end
                        ifh_pkg::CMD_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = ifh_pkg::ST_CLEAR;
                        end
                        ifh_pkg::CMD_QUERY:
                        begin
                            mem_raddr  = '0;
                            addr_next  = '0;
                            top_next   = AddrBits'(head_cmd.top);
                            best_next  = '0;
                            max_next   = '0;
                            state_next = ifh_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            emit                   = 1'b1;
                            emit_data.out_of_range = head_cmd.out_of_range;
                        end
                    endcase
                end
            end
            ifh_pkg::ST_UPDATE:
            begin
                mem_we            = 1'b1;
                mem_wdata         = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
                emit              = 1'b1;
                emit_data.counted = 1'b1;
                state_next        = ifh_pkg::ST_IDLE;
            end
            ifh_pkg::ST_SCAN:
            begin
                if (rd_data_reg > max_reg)
                begin
                    max_next  = rd_data_reg;
                    best_next = addr_reg;
                end
                if (addr_reg == top_reg)
                begin
                    emit                 = 1'b1;
                    emit_data.found      = (max_next != '0);
                    emit_data.best_index = ifh_pkg::BIN_BITS'(best_next);
                    state_next           = ifh_pkg::ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    mem_raddr = addr_reg + 1'b1;
                end
            end
            default: state_next = ifh_pkg::ST_IDLE;
        endcase

        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ifh_pkg::ST_INIT;
            addr_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        best_reg <= best_next;
        max_reg  <= max_next;
        if (emit)
        begin
            result_reg <= emit_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

// ----- hw/rtl/interval_filtered_histogram.sv -----
// Saturating per-bin event histogram with an inclusive timestamp window and a
// max-bin query. Each transaction on the item channel yields exactly one transaction
// on the result channel, in order. A count event that falls inside the window is
// handled in the back end by reading its bin from the count memory and then writing
// the incremented value; an event that is dropped or outside the window, and an
// unused operation code, are answered straight from the idle state. A clear is taken
// from the queue and then writes each bin of the count memory in turn, and a query
// reads each bin scanned in turn (bins 0 through the smaller of highest_index and
// NUM_BINS-1). After reset the block clears the count memory one bin at a time and
// holds item_stall high until that pass is done; configuration writes are taken at
// any time. A two-entry command queue lets new items be accepted while the back end
// is busy.
module interval_filtered_histogram #(
    parameter int NUM_BINS   = ifh_pkg::DEF_NUM_BINS,
    parameter int COUNT_BITS = ifh_pkg::DEF_COUNT_BITS,
    parameter int INDEX_BITS = ifh_pkg::DEF_INDEX_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  ifh_pkg::item_t                      item_data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output ifh_pkg::result_t                    result_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ifh_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ifh_pkg::TIME_BITS-1:0]       cfg_data
);

    logic          init_busy;
    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    ifh_pkg::cmd_t q_cmd;
    ifh_pkg::cmd_t head_cmd;

    ifh_front #(
        .NUM_BINS   (NUM_BINS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .init_busy  (init_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    ifh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    ifh_back #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_cmd     (head_cmd),
        .q_pop        (q_pop),
        .init_busy    (init_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    a_no_accept_during_init: assert property (
        @(posedge clk) disable iff (!rst_n)
        init_busy |-> !q_push
    ) else $error("Item accepted during the clearing pass.");

    a_queue_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(q_full && q_push && !q_pop)
    ) else $error("Command queue overflow.");

    a_queue_no_underflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(q_empty && q_pop)
    ) else $error("Command queue underflow.");

    a_result_flags_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> $countones({result_data.counted, result_data.out_of_range,
                                     result_data.found}) <= 1
    ) else $error("Result carries flags of more than one operation.");

    a_best_zero_when_not_found: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result_data.found) |-> (result_data.best_index == '0)
    ) else $error("Nonzero best index without a found bin.");

endmodule
